/* hw/rtl/lmmbq_pkg.sv */
package lmmbq_pkg;

    // Field widths of the channel words
    localparam int OP_W     = 3;
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LCOUNT_W = 5;
    localparam int LSIZE_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd0;
    localparam logic [OP_W-1:0] OP_DISCARD = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_MIN = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_MAX = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_LAYER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [LCOUNT_W-1:0] layer_count;
        logic [LSIZE_W-1:0]  top_layer_size;
    } out_word_t;

endpackage

/* hw/rtl/lmmbq_ram.sv */
module lmmbq_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/layered_min_max_bucket_queue_core.sv */
// Layered min/max bucket queue.
// Input channel: item_valid / item_stall / item carries one word (op, key, value_in).
// Output channel: result_valid / result_stall / result returns one word per input
// word (value_out, status, layer_count, top_layer_size), in order.
// Entries live in one flat memory of CAPACITY slots ordered by layer and push
// order; the base of each open layer sits in a second memory of MAX_LAYERS slots.
// Open, push, failed and unknown operations go straight to the done state; a
// discard that uncovers a lower layer first reads that layer's base from the
// base memory. A pop is set by the entry memory's single read port: one entry
// is scanned per cycle to find the extreme key of the top layer, then one entry
// per cycle above the removed one is moved down to close the gap. From the
// done state the result word is loaded into the output register.
// One word is worked on at a time; the next word is taken in the cycle after
// the previous result has been handed to the output register, so a new word is
// never taken before the last is through. A stalled result holds in the output
// register; a later finished result then waits and the input stays stalled.
// Reset empties the queue (no layers open, no entries) and clears result_valid;
// the memories are not cleared, since only written entries are ever used.
module layered_min_max_bucket_queue_core #(
    parameter int CAPACITY   = 64,
    parameter int MAX_LAYERS = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  lmmbq_pkg::in_word_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output lmmbq_pkg::out_word_t result
);

    import lmmbq_pkg::*;

    localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW      = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int EW      = KW + VW;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int LAY_W   = $clog2(MAX_LAYERS + 1);
    localparam int LADDR_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT0 = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DISC   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LAY_W-1:0]  layers_reg, layers_next;
    logic [CNT_W-1:0]  top_base_reg, top_base_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [KW-1:0]     best_key_reg, best_key_next;
    logic [VW-1:0]     best_val_reg, best_val_next;
    logic              first_reg, first_next;
    logic              want_max_reg, want_max_next;
    out_word_t         res_reg, res_next;
    out_word_t         result_reg;
    logic              result_valid_reg;

    logic              e_we;
    logic [ADDR_W-1:0] e_waddr, e_raddr;
    logic [EW-1:0]     e_wdata, e_rdata;
    logic              b_we;
    logic [LADDR_W-1:0] b_waddr, b_raddr;
    logic [CNT_W-1:0]  b_wdata, b_rdata;

    logic              accept;
    logic              out_free;
    logic              pop_fin;
    logic              take;
    logic [KW-1:0]     rd_key;
    logic [VW-1:0]     rd_val;
    logic [CNT_W-1:0]  best_ext;
    logic [LAY_W-1:0]  layers_m2;
    logic [LSIZE_W-1:0] size_now;

    lmmbq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (EW),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    lmmbq_ram #(
        .DEPTH  (MAX_LAYERS),
        .WIDTH  (CNT_W),
        .ADDR_W (LADDR_W)
    ) u_base_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign rd_key    = e_rdata[EW-1:VW];
    assign rd_val    = e_rdata[VW-1:0];
    assign best_ext  = CNT_W'(best_idx_reg);
    assign layers_m2 = layers_reg - LAY_W'(2);
    assign size_now  = (layers_reg == '0) ? '0 : LSIZE_W'(count_reg - top_base_reg);

    // Keep the later entry on equal keys
    always_comb
    begin
        if (want_max_reg)
        begin
            take = first_reg || (rd_key >= best_key_reg);
        end
        else
        begin
            take = first_reg || (rd_key <= best_key_reg);
        end
    end

    // Sequence the operations over the two memories
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        layers_next   = layers_reg;
        top_base_next = top_base_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        wr_idx_next   = wr_idx_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_val_next = best_val_reg;
        first_next    = first_reg;
        want_max_next = want_max_reg;
        res_next      = res_reg;
        pop_fin       = 1'b0;

        e_we    = 1'b0;
        e_waddr = count_reg[ADDR_W-1:0];
        e_wdata = {KW'(item.key), VW'(item.value_in)};
        e_raddr = rd_idx_reg[ADDR_W-1:0];
        b_we    = 1'b0;
        b_waddr = layers_reg[LADDR_W-1:0];
        b_wdata = count_reg;
        b_raddr = layers_m2[LADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.value_out      = '0;
                    res_next.status         = STATUS_OK;
                    res_next.layer_count    = LCOUNT_W'(layers_reg);
                    res_next.top_layer_size = size_now;
                    state_next              = S_DONE;
                    unique case (item.op)
                        OP_OPEN:
                        begin
                            if (32'(layers_reg) >= MAX_LAYERS)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                b_we                    = 1'b1;
                                top_base_next           = count_reg;
                                layers_next             = layers_reg + 1'b1;
                                res_next.layer_count    = LCOUNT_W'(layers_reg + 1'b1);
                                res_next.top_layer_size = '0;
                            end
                        end
                        OP_DISCARD:
                        begin
                            if (layers_reg == '0)
                            begin
                                res_next.status = STATUS_NO_LAYER;
                            end
                            else
                            begin
                                count_next           = top_base_reg;
                                layers_next          = layers_reg - 1'b1;
                                res_next.layer_count = LCOUNT_W'(layers_reg - 1'b1);
                                res_next.top_layer_size = '0;
                                if (layers_reg > LAY_W'(1))
                                begin
                                    state_next = S_DISC;
                                end
                            end
                        end
                        OP_PUSH:
                        begin
                            if (layers_reg == '0)
                            begin
                                res_next.status = STATUS_NO_LAYER;
                            end
                            else if (32'(count_reg) >= CAPACITY)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                e_we       = 1'b1;
                                count_next = count_reg + 1'b1;
                                res_next.top_layer_size =
                                    LSIZE_W'(count_reg + 1'b1 - top_base_reg);
                            end
                        end
                        OP_POP_MIN, OP_POP_MAX:
                        begin
                            if (layers_reg == '0)
                            begin
                                res_next.status = STATUS_NO_LAYER;
                            end
                            else if (count_reg <= top_base_reg)
                            begin
                                res_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                e_raddr       = top_base_reg[ADDR_W-1:0];
                                rd_idx_next   = top_base_reg + 1'b1;
                                cmp_idx_next  = top_base_reg[ADDR_W-1:0];
                                first_next    = 1'b1;
                                want_max_next = (item.op == OP_POP_MAX);
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DISC:
            begin
                top_base_next           = b_rdata;
                res_next.top_layer_size = LSIZE_W'(top_base_reg - b_rdata);
                state_next              = S_DONE;
            end
            S_SCAN:
            begin
                // Compare the arriving entry, fetch the next
                if (take)
                begin
                    best_idx_next = cmp_idx_reg;
                    best_key_next = rd_key;
                    best_val_next = rd_val;
                end
                first_next   = 1'b0;
                cmp_idx_next = cmp_idx_reg + 1'b1;
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (CNT_W'(cmp_idx_reg) == count_reg - 1'b1)
                begin
                    state_next = S_SHIFT0;
                end
            end
            S_SHIFT0:
            begin
                if (best_ext + 1'b1 < count_reg)
                begin
                    e_raddr     = ADDR_W'(best_ext + 1'b1);
                    rd_idx_next = CNT_W'(best_ext + CNT_W'(2));
                    wr_idx_next = best_idx_reg;
                    state_next  = S_SHIFT;
                end
                else
                begin
                    pop_fin = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Move one entry down, fetch the one above it
                e_we    = 1'b1;
                e_waddr = wr_idx_reg;
                e_wdata = e_rdata;
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                else
                begin
                    pop_fin = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close a pop: drop one entry and report the removed value
        if (pop_fin)
        begin
            count_next              = count_reg - 1'b1;
            res_next.value_out      = VALUE_W'(best_val_reg);
            res_next.status         = STATUS_OK;
            res_next.layer_count    = LCOUNT_W'(layers_reg);
            res_next.top_layer_size = LSIZE_W'(count_reg - 1'b1 - top_base_reg);
            state_next              = S_DONE;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            layers_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            layers_reg <= layers_next;
            if (state_reg == S_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Hold working payload and the output word
    always_ff @(posedge clk)
    begin
        top_base_reg <= top_base_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        wr_idx_reg   <= wr_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_val_reg <= best_val_next;
        first_reg    <= first_next;
        want_max_reg <= want_max_next;
        res_reg      <= res_next;
        if (state_reg == S_DONE && out_free)
        begin
            result_reg <= res_reg;
        end
    end

endmodule

/* dv/tb_layered_min_max_bucket_queue_core.sv */
`timescale 1ns / 1ps

module tb_layered_min_max_bucket_queue_core;

    import lmmbq_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int MAX_LAYERS     = 16;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int OPS_PER_PHASE  = 300;
    localparam int SETTLE_CYCLES  = 8;

    // Spare opcodes, which the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    // Operation mixes for the random part
    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DEEPEN, MIX_DRAIN} op_mix_t;

    class bucket_queue_scoreboard;
        logic [KEY_W-1:0]   slot_key [CAPACITY];
        logic [VALUE_W-1:0] slot_value [CAPACITY];
        int unsigned        used_slots;
        int unsigned        layer_base [MAX_LAYERS];
        int unsigned        open_layers;
        out_word_t          due_results [$];
        int unsigned        mismatches;

        function new();
            used_slots  = 0;
            open_layers = 0;
            mismatches  = 0;
        endfunction

        // Remove the extreme key of the top layer; later entries win ties
        function logic [VALUE_W-1:0] take_extreme(bit want_max);
            int unsigned        best;
            int unsigned        i;
            logic [VALUE_W-1:0] taken;
            best = layer_base[open_layers - 1];
            for (i = best + 1; i < used_slots; i++)
            begin
                if (want_max ? (slot_key[i] >= slot_key[best])
                             : (slot_key[i] <= slot_key[best]))
                    best = i;
            end
            taken = slot_value[best];
            // Close the gap left by the removed entry
            for (i = best; i + 1 < used_slots; i++)
            begin
                slot_key[i]   = slot_key[i + 1];
                slot_value[i] = slot_value[i + 1];
            end
            used_slots--;
            return taken;
        endfunction

        function out_word_t predict_result(in_word_t w);
            out_word_t r;
            r = '0;
            case (w.op)
                OP_OPEN:
                begin
                    if (open_layers >= MAX_LAYERS)
                        r.status = STATUS_FULL;
                    else
                    begin
                        layer_base[open_layers] = used_slots;
                        open_layers++;
                    end
                end
                OP_DISCARD:
                begin
                    if (open_layers == 0)
                        r.status = STATUS_NO_LAYER;
                    else
                    begin
                        used_slots = layer_base[open_layers - 1];
                        open_layers--;
                    end
                end
                OP_PUSH:
                begin
                    if (open_layers == 0)
                        r.status = STATUS_NO_LAYER;
                    else if (used_slots >= CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        slot_key[used_slots]   = w.key;
                        slot_value[used_slots] = w.value_in;
                        used_slots++;
                    end
                end
                OP_POP_MIN, OP_POP_MAX:
                begin
                    if (open_layers == 0)
                        r.status = STATUS_NO_LAYER;
                    else if (used_slots <= layer_base[open_layers - 1])
                        r.status = STATUS_EMPTY;
                    else
                        r.value_out = take_extreme(w.op == OP_POP_MAX);
                end
                default: ;
            endcase
            if (open_layers > 0)
                r.top_layer_size = LSIZE_W'(used_slots - layer_base[open_layers - 1]);
            r.layer_count = LCOUNT_W'(open_layers);
            return r;
        endfunction

        function void note_word(in_word_t w);
            due_results.push_back(predict_result(w));
        endfunction

        function void flag_field(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result word with none due, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            if (got.value_out !== want.value_out)
                flag_field("value_out", want.value_out, got.value_out);
            if (got.status !== want.status)
                flag_field("status", want.status, got.status);
            if (got.layer_count !== want.layer_count)
                flag_field("layer_count", want.layer_count, got.layer_count);
            if (got.top_layer_size !== want.top_layer_size)
                flag_field("top_layer_size", want.top_layer_size, got.top_layer_size);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    int unsigned sender_idle_pct;
    int unsigned stall_pct;
    int unsigned cycle_count = 0;

    bucket_queue_scoreboard queue_sb;

    layered_min_max_bucket_queue_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Check result words and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                queue_sb.check_result(result);
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("layered_min_max_bucket_queue_core test failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                           logic [VALUE_W-1:0] value_in);
        in_word_t w;
        w.op       = op;
        w.key      = key;
        w.value_in = value_in;
        return w;
    endfunction

    // Draw an operation from the weights of the current mix
    function automatic in_word_t random_word(op_mix_t mix);
        int unsigned      roll;
        int unsigned      c_open;
        int unsigned      c_discard;
        int unsigned      c_push;
        int unsigned      c_min;
        int unsigned      c_max;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        case (mix)
            MIX_FILL:
            begin
                c_open = 6;  c_discard = 8;  c_push = 90; c_min = 94; c_max = 98;
            end
            MIX_DEEPEN:
            begin
                c_open = 40; c_discard = 46; c_push = 80; c_min = 89; c_max = 98;
            end
            MIX_DRAIN:
            begin
                c_open = 5;  c_discard = 35; c_push = 48; c_min = 73; c_max = 98;
            end
            default:
            begin
                c_open = 10; c_discard = 18; c_push = 62; c_min = 79; c_max = 96;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < c_open)
            op = OP_OPEN;
        else if (roll < c_discard)
            op = OP_DISCARD;
        else if (roll < c_push)
            op = OP_PUSH;
        else if (roll < c_min)
            op = OP_POP_MIN;
        else if (roll < c_max)
            op = OP_POP_MAX;
        else
            op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
        // Narrow keys half the time so that ties are common
        if ($urandom_range(0, 1) == 0)
            key = KEY_W'($urandom_range(0, 7));
        else
            key = KEY_W'($urandom);
        return make_word(op, key, $urandom);
    endfunction

    // Offer one word, idling at random first, and hold it until taken
    task automatic send_word(in_word_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        queue_sb.note_word(w);
    endtask

    initial
    begin
        in_word_t    directed [$];
        in_word_t    w;
        op_mix_t     mix;
        int unsigned mix_left;
        int unsigned counted;
        int unsigned phase;

        queue_sb        = new();
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item            = '0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        mix             = MIX_BALANCED;
        mix_left        = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors with no layer open, spare opcodes, empty pops, extremes and ties
        directed.push_back(make_word(OP_POP_MIN, 16'h0001, 32'h0000_0001));
        directed.push_back(make_word(OP_POP_MAX, 16'h0002, 32'h0000_0002));
        directed.push_back(make_word(OP_PUSH, 16'h0003, 32'h0000_0003));
        directed.push_back(make_word(OP_DISCARD, 16'h0004, 32'h0000_0004));
        directed.push_back(make_word(OP_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(make_word(OP_SPARE_B, 16'h5A5A, 32'hA5A5_A5A5));
        directed.push_back(make_word(OP_SPARE_C, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_OPEN, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_POP_MIN, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_POP_MAX, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_PUSH, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(make_word(OP_PUSH, 16'h1234, 32'h0000_00A1));
        directed.push_back(make_word(OP_PUSH, 16'h1234, 32'h0000_00B2));
        directed.push_back(make_word(OP_POP_MAX, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_PUSH, 16'h0000, 32'h0000_00C3));
        directed.push_back(make_word(OP_POP_MIN, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_POP_MIN, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_OPEN, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_PUSH, 16'h0005, 32'h0000_00D4));
        directed.push_back(make_word(OP_DISCARD, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_POP_MAX, 16'h0000, 32'h0000_0000));
        directed.push_back(make_word(OP_DISCARD, 16'h0000, 32'h0000_0000));
        foreach (directed[i])
            send_word(directed[i]);

        // Random words over four phases of sender idling and output stalls
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 45; stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  stall_pct = 45;
                end
                default:
                begin
                    sender_idle_pct = 14; stall_pct = 14;
                end
            endcase
            counted = 0;
            while (counted < OPS_PER_PHASE)
            begin
                if (mix_left == 0)
                begin
                    mix      = op_mix_t'($urandom_range(MIX_BALANCED, MIX_DRAIN));
                    mix_left = $urandom_range(40, 120);
                end
                w = random_word(mix);
                send_word(w);
                mix_left--;
                if (w.op <= OP_POP_MAX)
                    counted++;
            end
        end
        item_valid <= 1'b0;

        // Drain outstanding results, then settle
        while (queue_sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (queue_sb.mismatches == 0)
            $display("layered_min_max_bucket_queue_core test passed");
        else
            $display("layered_min_max_bucket_queue_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lmmbq_pkg.sv
hw/rtl/lmmbq_ram.sv
hw/rtl/layered_min_max_bucket_queue_core.sv
dv/tb_layered_min_max_bucket_queue_core.sv
